// ----- rtl/bps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int unsigned DefMaxBackends = 16;
  localparam int unsigned WEIGHT_BITS    = 8;

  localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [2:0] REG_MODE_ADDR = 3'd0;

  localparam logic [2:0] CMD_SELECT    = 3'd0;
  localparam logic [2:0] CMD_ADD       = 3'd1;
  localparam logic [2:0] CMD_REMOVE    = 3'd2;
  localparam logic [2:0] CMD_STARTED   = 3'd3;
  localparam logic [2:0] CMD_COMPLETED = 3'd4;
  localparam logic [2:0] CMD_HEALTH    = 3'd5;

  localparam logic [2:0] MODE_RR     = 3'd0;
  localparam logic [2:0] MODE_LEAST  = 3'd1;
  localparam logic [2:0] MODE_WRR    = 3'd2;
  localparam logic [2:0] MODE_HASH   = 3'd3;
  localparam logic [2:0] MODE_RANDOM = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] client_hash;
    logic [31:0] backend_addr;
    logic [15:0] backend_port;
    logic [7:0]  backend_weight;
    logic [3:0]  entry_index;
    logic        request_ok;
    logic        health_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_index;
    logic [31:0] chosen_addr;
    logic [15:0] chosen_port;
    logic [15:0] active_now;
    logic [31:0] requests_total;
    logic [31:0] requests_failed;
    logic [4:0]  healthy_entries;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0]            addr;
    logic [15:0]            port;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   healthy;
    logic [15:0]            active;
    logic [31:0]            total;
    logic [31:0]            failed;
  } entry_t;

  function automatic logic [31:0] lfsr_step(logic [31:0] s);
    lfsr_step = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

  // Counts are filled in when the result is handed to the output register.
  function automatic out_item_t make_result(logic [1:0] st, logic [3:0] idx, entry_t e);
    out_item_t r;
    r                 = '0;
    r.status          = st;
    r.chosen_index    = idx;
    r.chosen_addr     = e.addr;
    r.chosen_port     = e.port;
    r.active_now      = e.active;
    r.requests_total  = e.total;
    r.requests_failed = e.failed;
    make_result       = r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bps_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bps_divider
  import bps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] trial;

  // One restoring step per cycle, most significant dividend bit first.
  assign trial = {rem_q, dvd_q[31]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 32'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/bps_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bps_table
  import bps_pkg::*;
#(
  parameter int unsigned MaxBackends = DefMaxBackends,
  localparam int unsigned IdxW       = (MaxBackends > 1) ? $clog2(MaxBackends) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire entry_t          wr_entry_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output entry_t               rd_entry_o
);

  entry_t slots_q [MaxBackends];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slots_q[wr_idx_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = slots_q[rd_idx_i];

endmodule

`default_nettype wire

// ----- rtl/backend_pool_selector_unit.sv -----
// Backend pool selector: keeps a compacted table of backends and answers
// one command per input beat (select, add, remove, request started, request
// completed, set health) with exactly one result beat.
// Input and output channels use valid/ready; a beat moves when both are high.
// The selection mode is written over the APB port at byte address 0; write
// it only while no command is in flight.
// Add, started, completed, set health and bad commands end in the execute
// state. Remove scans entries for a match, then shifts each later entry down.
// Select scans the whole table for least connections; round robin, hash and
// random use the shared remainder unit and then walk the table; weighted
// round robin sums the weights first, then uses the remainder unit and scans.
// One command is worked on at a time, and the remainder unit and the single
// table read port set the pace.
// The finished result sits in an output register, so the next command is
// taken while it waits; a stalled receiver holds the block only once a
// second result is ready.
// Reset empties the table, clears the rotation counter, mode and output
// valid, and loads the LFSR seed. Table contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module backend_pool_selector_unit
  import bps_pkg::*;
#(
  parameter int unsigned MaxBackends = DefMaxBackends
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned IdxW = (MaxBackends > 1) ? $clog2(MaxBackends) : 1;
  localparam int unsigned CntW = $clog2(MaxBackends + 1);
  localparam int unsigned SumW = CntW + WEIGHT_BITS;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_EXEC    = 11'b000_0000_0010,
    S_DIV     = 11'b000_0000_0100,
    S_RR      = 11'b000_0000_1000,
    S_LEAST   = 11'b000_0001_0000,
    S_WSUM    = 11'b000_0010_0000,
    S_WSCAN   = 11'b000_0100_0000,
    S_KTH     = 11'b000_1000_0000,
    S_RMSCAN  = 11'b001_0000_0000,
    S_RMSHIFT = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  logic [2:0]       mode_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  hcnt_q, hcnt_d;
  logic [31:0]      rot_q, rot_d;
  logic [31:0]      lfsr_q, lfsr_d;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic [CntW-1:0]  att_q, att_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [31:0]      k_q, k_d;
  logic             found_q, found_d;
  logic [15:0]      best_q, best_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             out_load;

  logic             div_start, div_busy, div_done;
  logic [31:0]      div_dvd, div_dvs, div_rem;

  logic             wr_en;
  logic [IdxW-1:0]  wr_idx, rd_idx;
  entry_t           wr_entry, rd_entry;

  logic [CntW-1:0]  scan_ext;
  logic             last;
  logic             cfg_write;

  assign scan_ext = CntW'(scan_q);
  assign last     = ((scan_ext + CntW'(1)) == cnt_q);

  bps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  bps_table #(
    .MaxBackends (MaxBackends)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry)
  );

  always_comb begin
    entry_t          upd;
    logic [SumW-1:0] cum;
    logic [CntW-1:0] att_n;
    state_d   = state_q;
    item_d    = item_q;
    cnt_d     = cnt_q;
    hcnt_d    = hcnt_q;
    rot_d     = rot_q;
    lfsr_d    = lfsr_q;
    scan_d    = scan_q;
    att_d     = att_q;
    sum_d     = sum_q;
    k_d       = k_q;
    found_d   = found_q;
    best_d    = best_q;
    res_d     = res_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_dvd   = rot_q;
    div_dvs   = 32'(cnt_q);
    wr_en     = 1'b0;
    wr_idx    = scan_q;
    wr_entry  = rd_entry;
    rd_idx    = scan_q;
    upd       = rd_entry;
    cum       = sum_q + (rd_entry.healthy ? SumW'(rd_entry.weight) : SumW'(0));
    att_n     = att_q + CntW'(1);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        scan_d  = '0;
        att_d   = '0;
        sum_d   = '0;
        found_d = 1'b0;
        res_d   = make_result(ST_NONE, '0, '0);
        state_d = S_DONE;
        case (item_q.command)
          CMD_SELECT: begin
            if (cnt_q != '0) begin
              case (mode_q)
                MODE_RR: begin
                  div_start = 1'b1;
                  state_d   = S_DIV;
                end
                MODE_LEAST: state_d = S_LEAST;
                MODE_WRR:   state_d = S_WSUM;
                MODE_HASH: begin
                  if (hcnt_q != '0) begin
                    div_start = 1'b1;
                    div_dvd   = item_q.client_hash;
                    div_dvs   = 32'(hcnt_q);
                    state_d   = S_DIV;
                  end
                end
                MODE_RANDOM: begin
                  if (hcnt_q != '0) begin
                    lfsr_d    = lfsr_step(lfsr_q);
                    div_start = 1'b1;
                    div_dvd   = lfsr_step(lfsr_q);
                    div_dvs   = 32'(hcnt_q);
                    state_d   = S_DIV;
                  end
                end
                default: ;
              endcase
            end
          end
          CMD_ADD: begin
            if (cnt_q == CntW'(MaxBackends)) begin
              res_d = make_result(ST_FULL, '0, '0);
            end else begin
              upd.addr    = item_q.backend_addr;
              upd.port    = item_q.backend_port;
              upd.weight  = WEIGHT_BITS'(item_q.backend_weight);
              upd.healthy = 1'b1;
              upd.active  = '0;
              upd.total   = '0;
              upd.failed  = '0;
              wr_en       = 1'b1;
              wr_idx      = IdxW'(cnt_q);
              wr_entry    = upd;
              res_d       = make_result(ST_OK, 4'(cnt_q), upd);
              cnt_d       = cnt_q + CntW'(1);
              hcnt_d      = hcnt_q + CntW'(1);
            end
          end
          CMD_REMOVE: begin
            if (cnt_q != '0) begin
              state_d = S_RMSCAN;
            end
          end
          CMD_STARTED, CMD_COMPLETED, CMD_HEALTH: begin
            rd_idx = IdxW'(item_q.entry_index);
            if (32'(item_q.entry_index) >= 32'(cnt_q)) begin
              res_d = make_result(ST_BAD_INDEX, '0, '0);
            end else begin
              if (item_q.command == CMD_STARTED) begin
                if (rd_entry.active != 16'hFFFF) upd.active = rd_entry.active + 16'd1;
                if (rd_entry.total != 32'hFFFF_FFFF) upd.total = rd_entry.total + 32'd1;
              end else if (item_q.command == CMD_COMPLETED) begin
                if (rd_entry.active != '0) upd.active = rd_entry.active - 16'd1;
                if (!item_q.request_ok && rd_entry.failed != 32'hFFFF_FFFF) begin
                  upd.failed = rd_entry.failed + 32'd1;
                end
              end else begin
                upd.healthy = item_q.health_value;
                hcnt_d = hcnt_q + CntW'(item_q.health_value) - CntW'(rd_entry.healthy);
              end
              wr_en    = 1'b1;
              wr_idx   = IdxW'(item_q.entry_index);
              wr_entry = upd;
              res_d    = make_result(ST_OK, item_q.entry_index, upd);
            end
          end
          default: ;
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          k_d    = div_rem;
          scan_d = '0;
          sum_d  = '0;
          case (mode_q)
            MODE_RR: begin
              scan_d  = IdxW'(div_rem);
              state_d = S_RR;
            end
            MODE_WRR: state_d = S_WSCAN;
            default:  state_d = S_KTH;
          endcase
        end
      end

      S_RR: begin
        // Each probe is one attempt of the rotation counter.
        att_d  = att_n;
        scan_d = last ? '0 : scan_q + IdxW'(1);
        if (rd_entry.healthy) begin
          rot_d   = rot_q + 32'(att_n);
          res_d   = make_result(ST_OK, 4'(scan_q), rd_entry);
          state_d = S_DONE;
        end else if (att_n == cnt_q) begin
          rot_d   = rot_q + 32'(cnt_q);
          res_d   = make_result(ST_NONE, '0, '0);
          state_d = S_DONE;
        end
      end

      S_LEAST: begin
        if (rd_entry.healthy && (!found_q || rd_entry.active < best_q)) begin
          found_d = 1'b1;
          best_d  = rd_entry.active;
          res_d   = make_result(ST_OK, 4'(scan_q), rd_entry);
        end
        scan_d = scan_q + IdxW'(1);
        if (last) begin
          if (!found_d) res_d = make_result(ST_NONE, '0, '0);
          state_d = S_DONE;
        end
      end

      S_WSUM: begin
        sum_d  = cum;
        scan_d = scan_q + IdxW'(1);
        if (last) begin
          if (cum == '0) begin
            res_d   = make_result(ST_NONE, '0, '0);
            state_d = S_DONE;
          end else begin
            div_start = 1'b1;
            div_dvs   = 32'(cum);
            rot_d     = rot_q + 32'd1;
            state_d   = S_DIV;
          end
        end
      end

      S_WSCAN: begin
        sum_d  = cum;
        scan_d = scan_q + IdxW'(1);
        if (rd_entry.healthy && (k_q < 32'(cum))) begin
          res_d   = make_result(ST_OK, 4'(scan_q), rd_entry);
          state_d = S_DONE;
        end else if (last) begin
          res_d   = make_result(ST_NONE, '0, '0);
          state_d = S_DONE;
        end
      end

      S_KTH: begin
        scan_d = scan_q + IdxW'(1);
        if (rd_entry.healthy && (k_q == '0)) begin
          res_d   = make_result(ST_OK, 4'(scan_q), rd_entry);
          state_d = S_DONE;
        end else begin
          if (rd_entry.healthy) k_d = k_q - 32'd1;
          if (last) begin
            res_d   = make_result(ST_NONE, '0, '0);
            state_d = S_DONE;
          end
        end
      end

      S_RMSCAN: begin
        if (rd_entry.addr == item_q.backend_addr && rd_entry.port == item_q.backend_port) begin
          res_d = make_result(ST_OK, 4'(scan_q), rd_entry);
          if (rd_entry.healthy) hcnt_d = hcnt_q - CntW'(1);
          if (last) begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_RMSHIFT;
          end
        end else begin
          scan_d = scan_q + IdxW'(1);
          if (last) begin
            res_d   = make_result(ST_NONE, '0, '0);
            state_d = S_DONE;
          end
        end
      end

      S_RMSHIFT: begin
        // Move the next entry down into the hole, one entry per cycle.
        rd_idx = scan_q + IdxW'(1);
        wr_en  = 1'b1;
        wr_idx = scan_q;
        scan_d = scan_q + IdxW'(1);
        if ((scan_ext + CntW'(2)) == cnt_q) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d                 = res_q;
    out_d.healthy_entries = 5'(hcnt_q);
    out_d.entry_count     = 5'(cnt_q);
  end

  assign cfg_write = psel && penable && pwrite && (paddr == REG_MODE_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hcnt_q      <= '0;
      rot_q       <= '0;
      lfsr_q      <= LFSR_SEED;
      mode_q      <= MODE_RR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hcnt_q  <= hcnt_d;
      rot_q   <= rot_d;
      lfsr_q  <= lfsr_d;
      if (cfg_write) mode_q <= pwdata[2:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    scan_q  <= scan_d;
    att_q   <= att_d;
    sum_q   <= sum_d;
    k_q     <= k_d;
    found_q <= found_d;
    best_q  <= best_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == REG_MODE_ADDR) ? 32'(mode_q) : '0;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register is not one-hot");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MaxBackends) else $error("entry count beyond table size");

  a_healthy_le_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= cnt_q) else $error("more healthy entries than entries");

  a_div_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle remainder unit");

  a_load_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the done state");
`endif

endmodule

`default_nettype wire
